// File: hw/rtl/dfb_pkg.sv
// Constants, types and helpers for the distance fog blend pipeline.
// Used by distance_fog_blend; depends on nothing else.
package dfb_pkg;

	localparam int POS_W = 32;
	localparam int DIF_W = 33;
	localparam int SQ_W = 66;
	localparam int SUM_W = 68;
	localparam int ROOT_W = 34;
	localparam int FD_W = 34;
	localparam int PRD_W = 50;
	localparam int NP_W = 51;
	localparam int NUM_W = 38;
	localparam int DEN_W = 35;
	localparam int QT_W = 18;
	localparam int DCMP_W = DEN_W + QT_W;
	localparam int X_W = 34;
	localparam int N_W = 5;
	localparam int R_W = 30;
	localparam int T_W = 31;
	localparam int P_W = 60;
	localparam int F_W = 17;
	localparam int COL_W = 16;
	localparam int HORNER_K = 10;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	// Pipeline depth: differences, squares, sum, root, fog distance, product,
	// divider setup, divider, square, range reduction, series, factor,
	// blend products and output.
	localparam int LAT = 3 + ROOT_W + 3 + QT_W + 1 + N_W + 3 * HORNER_K + 1 + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd5;

	localparam logic [DEN_W-1:0] RECIP_K = 35'd2560000;
	localparam logic [NUM_W-1:0] RECIP_NUM = 38'd167772160000;
	localparam logic [NP_W-1:0] EXP_BIAS = 51'd10000;
	localparam logic [NP_W-1:0] EXP_LIMIT = 51'd5242880000;
	localparam logic [DEN_W-1:0] EXP_DIV = 35'd20000;
	localparam logic [X_W:0] LN2_Q30 = 35'd744261118;
	localparam logic [T_W-1:0] ONE_Q30 = 31'h40000000;
	localparam logic [F_W-1:0] F_ONE = 17'h10000;

	typedef struct packed {
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
	} col_t;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic sat;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QT_W-1:0] quo;
	} dv_t;

	typedef struct packed {
		logic sat;
		logic [QT_W-1:0] quo;
		logic [X_W-1:0] xr;
		logic [N_W-1:0] n;
		logic [T_W-1:0] t;
		logic [P_W-1:0] p;
		logic [R_W-1:0] v;
		logic [T_W-1:0] q0;
	} exp_t;

	function automatic logic [DIF_W-1:0] abs_diff(logic signed [POS_W-1:0] p,
			logic signed [POS_W-1:0] e);
		logic signed [DIF_W-1:0] d;
		d = DIF_W'(p) - DIF_W'(e);
		return d[DIF_W-1] ? DIF_W'(-d) : DIF_W'(d);
	endfunction

endpackage

// File: hw/rtl/distance_fog_blend.sv
// Distance fog blend: one fragment word in, one fogged color word out.
// Depends on dfb_pkg for widths, constants, stage types and helpers.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, pixel_*, point_*, eye_* | into block
//  out     | out_valid, out_ready, out_red/green/blue  | out of block
//  cfg     | cfg_write, cfg_index, cfg_data            | into block
//
// One word is accepted per cycle while in_ready is high, that is, while the output is not stalled.
// The depth is set by the 34-step square root, the 18-step divider, the
// 5-step range reduction and the ten series steps of three stages each.
// Reset clears all valid bits and loads the register defaults.
// When a result waits and out_ready is low, every stage holds as one.
module distance_fog_blend (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [dfb_pkg::COL_W-1:0] pixel_red,
	input logic [dfb_pkg::COL_W-1:0] pixel_green,
	input logic [dfb_pkg::COL_W-1:0] pixel_blue,
	input logic signed [dfb_pkg::POS_W-1:0] point_x,
	input logic signed [dfb_pkg::POS_W-1:0] point_y,
	input logic signed [dfb_pkg::POS_W-1:0] point_z,
	input logic signed [dfb_pkg::POS_W-1:0] eye_x,
	input logic signed [dfb_pkg::POS_W-1:0] eye_y,
	input logic signed [dfb_pkg::POS_W-1:0] eye_z,
	output logic out_valid,
	input logic out_ready,
	output logic [dfb_pkg::COL_W-1:0] out_red,
	output logic [dfb_pkg::COL_W-1:0] out_green,
	output logic [dfb_pkg::COL_W-1:0] out_blue,
	input logic cfg_write,
	input logic [dfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dfb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dfb_pkg::*;

	logic [15:0] density_q;
	logic [30:0] start_q;
	logic [COL_W-1:0] fog_q [3];
	logic mode_q;

	logic adv;
	logic vld_s [LAT];
	col_t col_s [LAT-2];

	logic [DIF_W-1:0] dif_s1 [3];
	logic [SQ_W-1:0] sq_s2 [3];
	logic [SUM_W-1:0] sum_s3;
	sqrt_t sqr_s [ROOT_W];
	logic [FD_W-1:0] fd_s38;
	logic [PRD_W-1:0] prd_s39;
	logic [DEN_W-1:0] den_s39;
	dv_t dvi_s40;
	dv_t dv_s [QT_W];
	exp_t x_s59;
	exp_t nd_s [N_W];
	exp_t hra_s [HORNER_K];
	exp_t hrb_s [HORNER_K];
	exp_t hrc_s [HORNER_K];
	logic [F_W-1:0] f_s95;
	logic [32:0] am_s96 [3];
	logic [32:0] bm_s96 [3];
	logic [COL_W-1:0] out_s97 [3];

	assign adv = !vld_s[LAT-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_s[LAT-1];
	assign out_red = out_s97[0];
	assign out_green = out_s97[1];
	assign out_blue = out_s97[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q <= 16'd256;
			start_q <= 31'd2560;
			fog_q[0] <= 16'd32768;
			fog_q[1] <= 16'd39322;
			fog_q[2] <= 16'd45875;
			mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DENSITY: density_q <= cfg_data[15:0];
				CFG_START: start_q <= cfg_data;
				CFG_RED: fog_q[0] <= cfg_data[COL_W-1:0];
				CFG_GREEN: fog_q[1] <= cfg_data[COL_W-1:0];
				CFG_BLUE: fog_q[2] <= cfg_data[COL_W-1:0];
				CFG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s[0] <= '{r: pixel_red, g: pixel_green, b: pixel_blue};
			for (int i = 1; i < LAT - 2; i++) col_s[i] <= col_s[i-1];
		end
	end

	// Distance: absolute differences, squares, sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			dif_s1[0] <= abs_diff(point_x, eye_x);
			dif_s1[1] <= abs_diff(point_y, eye_y);
			dif_s1[2] <= abs_diff(point_z, eye_z);
			for (int i = 0; i < 3; i++) sq_s2[i] <= dif_s1[i] * dif_s1[i];
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	// Square root, one result bit per stage, most significant first.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - i;
		sqrt_t sin;
		sqrt_t sout;
		logic [SUM_W-1:0] trial;
		if (i == 0) begin : g_first
			assign sin = '{rem: sum_s3, root: '0};
		end else begin : g_next
			assign sin = sqr_s[i-1];
		end
		assign trial = (SUM_W'(sin.root) << (B + 1)) | (SUM_W'(1) << (2 * B));
		always_comb begin
			sout = sin;
			if (sin.rem >= trial) begin
				sout.rem = sin.rem - trial;
				sout.root = sin.root | (ROOT_W'(1) << B);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqr_s[i] <= sout;
			end
		end
	end

	// Fog distance, then the operands of the shared divider.
	always_ff @(posedge clk) begin
		logic [NP_W-1:0] np;
		logic sat;
		dv_t dn;
		if (adv) begin
			fd_s38 <= (sqr_s[ROOT_W-1].root > FD_W'(start_q)) ?
				sqr_s[ROOT_W-1].root - FD_W'(start_q) : '0;
			prd_s39 <= fd_s38 * density_q;
			den_s39 <= RECIP_K + DEN_W'(fd_s38);
			np = NP_W'(prd_s39) + EXP_BIAS;
			sat = np >= EXP_LIMIT;
			dn.quo = '0;
			if (mode_q) begin
				dn.sat = 1'b0;
				dn.rem = RECIP_NUM + NUM_W'(den_s39 >> 1);
				dn.den = den_s39;
			end else begin
				dn.sat = sat;
				dn.rem = sat ? '0 : np[NUM_W-1:0];
				dn.den = EXP_DIV;
			end
			dvi_s40 <= dn;
		end
	end

	// Restoring divider, one quotient bit per stage.
	for (genvar i = 0; i < QT_W; i++) begin : g_div
		localparam int B = QT_W - 1 - i;
		dv_t din;
		dv_t dout;
		logic [DCMP_W-1:0] dsh;
		if (i == 0) begin : g_first
			assign din = dvi_s40;
		end else begin : g_next
			assign din = dv_s[i-1];
		end
		assign dsh = DCMP_W'(din.den) << B;
		always_comb begin
			dout = din;
			if (DCMP_W'(din.rem) >= dsh) begin
				dout.rem = din.rem - dsh[NUM_W-1:0];
				dout.quo = din.quo | (QT_W'(1) << B);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i] <= dout;
			end
		end
	end

	// Square of the scaled distance in Q30.
	always_ff @(posedge clk) begin
		logic [2*QT_W-1:0] xq;
		exp_t xn;
		if (adv) begin
			xq = dv_s[QT_W-1].quo * dv_s[QT_W-1].quo;
			xn = '0;
			xn.sat = dv_s[QT_W-1].sat;
			xn.quo = dv_s[QT_W-1].quo;
			xn.xr = X_W'((xq + (2*QT_W)'(2)) >> 2);
			x_s59 <= xn;
		end
	end

	// Range reduction by ln 2: integer part into n, remainder stays in xr.
	for (genvar i = 0; i < N_W; i++) begin : g_red
		localparam int B = N_W - 1 - i;
		exp_t rin;
		exp_t rout;
		logic [X_W:0] lsh;
		if (i == 0) begin : g_first
			assign rin = x_s59;
		end else begin : g_next
			assign rin = nd_s[i-1];
		end
		assign lsh = LN2_Q30 << B;
		always_comb begin
			rout = rin;
			if ({1'b0, rin.xr} >= lsh) begin
				rout.xr = rin.xr - lsh[X_W-1:0];
				rout.n = rin.n | (N_W'(1) << B);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				nd_s[i] <= rout;
			end
		end
	end

	// Series for exp(-r) by Horner's rule, three stages per term.
	for (genvar j = 0; j < HORNER_K; j++) begin : g_hrn
		localparam int K = HORNER_K - j;
		localparam logic [32:0] RCP = 33'((64'd1 << 32) / 64'(K));
		exp_t hin;
		exp_t na;
		exp_t nb;
		exp_t nc;
		logic [R_W+T_W-1:0] pa;
		logic [R_W+32:0] mb;
		logic [T_W+3:0] qk;
		logic [T_W+3:0] rm;
		logic [T_W-1:0] qv;
		if (j == 0) begin : g_first
			always_comb begin
				hin = nd_s[N_W-1];
				hin.t = ONE_Q30;
			end
		end else begin : g_next
			assign hin = hrc_s[j-1];
		end
		assign pa = hin.xr[R_W-1:0] * hin.t;
		assign mb = hra_s[j].p[P_W-1:P_W-R_W] * RCP;
		assign qk = {4'b0, hrb_s[j].q0} * (T_W+4)'(K);
		assign rm = {5'b0, hrb_s[j].v} - qk;
		assign qv = hrb_s[j].q0 + T_W'(rm >= (T_W+4)'(K));
		always_comb begin
			na = hin;
			na.p = pa[P_W-1:0];
			nb = hra_s[j];
			nb.v = hra_s[j].p[P_W-1:P_W-R_W];
			nb.q0 = mb[R_W+32:32];
			nc = hrb_s[j];
			nc.t = ONE_Q30 - qv;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				hra_s[j] <= na;
				hrb_s[j] <= nb;
				hrc_s[j] <= nc;
			end
		end
	end

	// Fog factor in Q16, then the blend products and the rounded sum.
	always_ff @(posedge clk) begin
		exp_t hl;
		logic [5:0] sh;
		logic [T_W+1:0] tr;
		logic [F_W-1:0] fexp;
		logic [COL_W-1:0] pix [3];
		logic [33:0] acc;
		logic [17:0] bv;
		if (adv) begin
			hl = hrc_s[HORNER_K-1];
			sh = 6'(hl.n) + 6'd14;
			tr = {2'b0, hl.t} + ((T_W+2)'(1) << (sh - 6'd1));
			if (sh >= 6'd32) begin
				fexp = '0;
			end else begin
				fexp = F_W'(tr >> sh);
			end
			if (mode_q) begin
				f_s95 <= (hl.quo > QT_W'(F_ONE)) ? F_ONE : hl.quo[F_W-1:0];
			end else if (hl.sat) begin
				f_s95 <= '0;
			end else begin
				f_s95 <= (fexp > F_ONE) ? F_ONE : fexp;
			end
			pix[0] = col_s[LAT-3].r;
			pix[1] = col_s[LAT-3].g;
			pix[2] = col_s[LAT-3].b;
			for (int c = 0; c < 3; c++) begin
				am_s96[c] <= pix[c] * f_s95;
				bm_s96[c] <= fog_q[c] * (F_ONE - f_s95);
			end
			for (int c = 0; c < 3; c++) begin
				acc = 34'(am_s96[c]) + 34'(bm_s96[c]) + 34'd32768;
				bv = acc[33:16];
				out_s97[c] <= (bv > 18'd65535) ? 16'hFFFF : bv[COL_W-1:0];
			end
		end
	end

endmodule
